/* hdl/ipcr_pkg.sv */
`timescale 1ns / 1ps

package ipcr_pkg;

  // request codes as they arrive on req_type
  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_EDGE    = 3'd1,
    OP_TICK    = 3'd2,
    OP_CARRIER = 3'd3,
    OP_STOP    = 3'd4
  } ipcr_op_e;

  // configuration register indexes
  typedef enum logic {
    CFG_CLOCK_HZ   = 1'b0,
    CFG_TIME_LIMIT = 1'b1
  } ipcr_cfg_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_WIN,
    BK_EMIT_IV,
    BK_CHECK,
    BK_EMIT_SUM
  } ipcr_bk_state_e;

  localparam int CLK_W      = 28;
  localparam int LIMIT_W    = 32;
  localparam int TIMER_W    = 16;
  localparam int PERIOD_W   = 16;
  localparam int DUR_W      = 31;
  localparam int COUNT_W    = 9;
  localparam int HZ_W       = 16;

  localparam logic [CLK_W-1:0]   CLOCK_HZ_RST   = 28'd72000000;
  localparam logic [LIMIT_W-1:0] TIME_LIMIT_RST = 32'd5000000;

  localparam logic [TIMER_W-1:0] TICK_US     = 16'hFFFF;
  localparam logic [CLK_W-1:0]   CARRIER_MIN = 28'd29000;
  localparam logic [CLK_W-1:0]   CARRIER_MAX = 28'd60500;
  localparam logic [HZ_W-1:0]    SNAP_NEAR   = 16'd1001;

  localparam int DIV_STEPS = CLK_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int NSTEPS = 16;
  localparam logic [HZ_W-1:0] STD_STEPS [NSTEPS] = '{
    16'd30000, 16'd32000, 16'd34000, 16'd36000, 16'd38000, 16'd40000, 16'd42000, 16'd44000,
    16'd46000, 16'd48000, 16'd50000, 16'd52000, 16'd54000, 16'd56000, 16'd58000, 16'd60000
  };

  typedef struct packed {
    ipcr_op_e              op;
    logic [TIMER_W-1:0]    timer_count;
    logic                  pin_level;
    logic [PERIOD_W-1:0]   carrier_period;
  } ipcr_cmd_t;

  typedef struct packed {
    logic                  result_kind;
    logic                  signal_level;
    logic [DUR_W-1:0]      duration_us;
    logic [COUNT_W-1:0]    interval_count;
    logic [HZ_W-1:0]       carrier_hz;
    logic                  last;
  } ipcr_res_t;

  function automatic logic [HZ_W-1:0] absdiff(input logic [HZ_W-1:0] a,
                                               input logic [HZ_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // lowest step pair with either step within SNAP_NEAR wins; ties go up
  function automatic logic [HZ_W-1:0] snap_carrier(input logic [HZ_W-1:0] v);
    logic [HZ_W-1:0] res;
    logic [HZ_W-1:0] d1;
    logic [HZ_W-1:0] d2;
    res = '0;
    for (int i = NSTEPS - 2; i >= 0; i--) begin
      d1 = absdiff(STD_STEPS[i], v);
      d2 = absdiff(STD_STEPS[i+1], v);
      if (d1 < SNAP_NEAR || d2 < SNAP_NEAR) begin
        res = (d1 < d2) ? STD_STEPS[i] : STD_STEPS[i+1];
      end
    end
    return res;
  endfunction

endpackage

/* hdl/ipcr_front.sv */
`timescale 1ns / 1ps

module ipcr_front (
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  req_type_i,
  input  logic [15:0]                 timer_count_i,
  input  logic                        pin_level_i,
  input  logic [15:0]                 carrier_period_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output ipcr_pkg::ipcr_cmd_t         q_cmd_o
);
  import ipcr_pkg::*;

  ipcr_op_e op;
  logic     keep;

  assign op = ipcr_op_e'(req_type_i);

  // drop unused codes and empty carrier captures here
  always_comb begin
    case (op)
      OP_START, OP_EDGE, OP_TICK, OP_STOP: keep = 1'b1;
      OP_CARRIER:                          keep = (carrier_period_i != '0);
      default:                             keep = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

  assign q_cmd_o.op             = op;
  assign q_cmd_o.timer_count    = timer_count_i;
  assign q_cmd_o.pin_level      = pin_level_i;
  assign q_cmd_o.carrier_period = carrier_period_i;

endmodule

/* hdl/ipcr_fifo.sv */
`timescale 1ns / 1ps

module ipcr_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ipcr_pkg::ipcr_cmd_t cmd_i,
  input  logic                pop_i,
  output ipcr_pkg::ipcr_cmd_t cmd_o,
  output logic                full_o,
  output logic                empty_o
);
  import ipcr_pkg::*;

  ipcr_cmd_t         mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push;
  logic              do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

/* hdl/ipcr_back.sv */
`timescale 1ns / 1ps

module ipcr_back #(
  parameter int MAX_INTERVALS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [27:0]         clock_hz_i,
  input  logic [31:0]         time_limit_i,
  input  ipcr_pkg::ipcr_cmd_t q_cmd_i,
  input  logic                q_empty_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ipcr_pkg::ipcr_res_t out_res_o
);
  import ipcr_pkg::*;

  localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

  ipcr_bk_state_e state_q, state_d;

  logic               capturing_q;
  logic [DUR_W-1:0]   open_dur_q;
  logic               open_level_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [LIMIT_W-1:0] total_q;
  logic [HZ_W-1:0]    snap_hz_q;

  logic [DUR_W-1:0]   pend_dur_q;
  logic               pend_level_q;
  logic [CNT_W-1:0]   pend_cnt_q;

  logic [PERIOD_W-1:0]  div_rem_q;
  logic [CLK_W-1:0]     div_quo_q;
  logic [PERIOD_W-1:0]  div_den_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  logic      out_valid_q;
  ipcr_res_t out_q;

  logic               out_free;
  logic               stop_now;
  logic               load_iv;
  logic               load_sum;
  logic [16:0]        div_shift;
  logic               div_ge;
  logic [TIMER_W-1:0] time_add;
  logic [LIMIT_W:0]   total_sum;
  logic [LIMIT_W-1:0] total_sat;
  logic               in_window;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign stop_now  = (total_q > time_limit_i) || (cnt_q >= CNT_W'(MAX_INTERVALS));
  assign q_pop_o   = (state_q == BK_IDLE) && !q_empty_i;
  assign load_iv   = (state_q == BK_EMIT_IV) && out_free;
  assign load_sum  = (state_q == BK_EMIT_SUM) && out_free;

  assign div_shift = {div_rem_q, div_quo_q[CLK_W-1]};
  assign div_ge    = (div_shift >= {1'b0, div_den_q});
  assign in_window = (div_quo_q > CARRIER_MIN) && (div_quo_q < CARRIER_MAX);

  // total time saturates instead of wrapping
  assign time_add  = (q_cmd_i.op == OP_EDGE) ? q_cmd_i.timer_count : TICK_US;
  assign total_sum = {1'b0, total_q} + (LIMIT_W+1)'(time_add);
  assign total_sat = total_sum[LIMIT_W] ? '1 : total_sum[LIMIT_W-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (q_pop_o && capturing_q) begin
          case (q_cmd_i.op)
            OP_EDGE:    state_d = BK_EMIT_IV;
            OP_TICK:    state_d = BK_CHECK;
            OP_CARRIER: state_d = BK_DIV;
            OP_STOP:    state_d = BK_EMIT_SUM;
            default:    state_d = BK_IDLE;
          endcase
        end
      end
      BK_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = BK_WIN;
        end
      end
      BK_WIN:      state_d = BK_IDLE;
      BK_EMIT_IV: begin
        if (out_free) begin
          state_d = BK_CHECK;
        end
      end
      BK_CHECK:    state_d = stop_now ? BK_EMIT_SUM : BK_IDLE;
      BK_EMIT_SUM: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default:     state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capturing_q  <= 1'b0;
      open_dur_q   <= '0;
      open_level_q <= 1'b0;
      cnt_q        <= '0;
      total_q      <= '0;
      snap_hz_q    <= '0;
    end else begin
      if (q_pop_o) begin
        case (q_cmd_i.op)
          OP_START: begin
            capturing_q  <= 1'b1;
            open_dur_q   <= '0;
            open_level_q <= ~q_cmd_i.pin_level;
            cnt_q        <= '0;
            total_q      <= '0;
            snap_hz_q    <= '0;
          end
          OP_EDGE: begin
            if (capturing_q) begin
              cnt_q        <= cnt_q + 1'b1;
              open_dur_q   <= '0;
              open_level_q <= ~q_cmd_i.pin_level;
              total_q      <= total_sat;
            end
          end
          OP_TICK: begin
            if (capturing_q) begin
              open_dur_q <= open_dur_q + DUR_W'(TICK_US);
              total_q    <= total_sat;
            end
          end
          default: ;
        endcase
      end
      if (state_q == BK_WIN && in_window) begin
        snap_hz_q <= snap_carrier(div_quo_q[HZ_W-1:0]);
      end
      if (load_sum) begin
        capturing_q <= 1'b0;
      end
    end
  end

  // closed interval waiting for the output slot, and the period divider
  always_ff @(posedge clk_i) begin
    if (q_pop_o && q_cmd_i.op == OP_EDGE) begin
      pend_dur_q   <= open_dur_q + DUR_W'(q_cmd_i.timer_count);
      pend_level_q <= open_level_q;
      pend_cnt_q   <= cnt_q;
    end
    if (q_pop_o && q_cmd_i.op == OP_CARRIER) begin
      div_rem_q <= '0;
      div_quo_q <= clock_hz_i;
      div_den_q <= q_cmd_i.carrier_period;
      div_cnt_q <= '0;
    end else if (state_q == BK_DIV) begin
      // one quotient bit per cycle, restoring
      div_rem_q <= div_ge ? PERIOD_W'(div_shift - {1'b0, div_den_q})
                          : div_shift[PERIOD_W-1:0];
      div_quo_q <= {div_quo_q[CLK_W-2:0], div_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (out_valid_q && out_stall_i) || load_iv || load_sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_iv) begin
      out_q.result_kind    <= 1'b0;
      out_q.signal_level   <= pend_level_q;
      out_q.duration_us    <= pend_dur_q;
      out_q.interval_count <= COUNT_W'(pend_cnt_q);
      out_q.carrier_hz     <= '0;
      out_q.last           <= 1'b0;
    end else if (load_sum) begin
      out_q.result_kind    <= 1'b1;
      out_q.signal_level   <= 1'b0;
      out_q.duration_us    <= '0;
      out_q.interval_count <= COUNT_W'(cnt_q);
      out_q.carrier_hz     <= snap_hz_q;
      out_q.last           <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  a_div_needs_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> capturing_q)
    else $error("divider running outside a capture");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_INTERVALS))
    else $error("interval count beyond maximum");

  a_summary_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_sum |=> (out_valid_q && out_q.last && out_q.result_kind && !capturing_q))
    else $error("summary did not close the capture");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != BK_IDLE) |-> !q_pop_o)
    else $error("request taken while back end busy");

endmodule

/* hdl/ir_pulse_capture_recorder_unit.sv */
`timescale 1ns / 1ps

// IR pulse capture recorder: requests (start, edge, overflow tick, carrier
// capture, stop) enter a two-entry queue and are carried out one at a time.
// A stop during a capture emits a summary, as does a tick that takes the total
// past the time limit; an edge emits its closed interval and, if the capture
// then ends, a summary after it. A carrier capture runs the bit-serial 28-step
// divider that turns the period into hertz. Interval and summary results
// leave through a single output register and wait there while the output is
// stalled; the input keeps filling the queue meanwhile.
module ir_pulse_capture_recorder_unit #(
  parameter int MAX_INTERVALS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  req_type_i,
  input  logic [15:0] timer_count_i,
  input  logic        pin_level_i,
  input  logic [15:0] carrier_period_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic        signal_level_o,
  output logic [30:0] duration_us_o,
  output logic [8:0]  interval_count_o,
  output logic [15:0] carrier_hz_o,
  output logic        last_o
);
  import ipcr_pkg::*;

  logic [CLK_W-1:0]   clock_hz_q;
  logic [LIMIT_W-1:0] time_limit_q;

  ipcr_cmd_t push_cmd;
  ipcr_cmd_t head_cmd;
  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  ipcr_res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_hz_q   <= CLOCK_HZ_RST;
      time_limit_q <= TIME_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (ipcr_cfg_e'(cfg_index_i))
        CFG_CLOCK_HZ:   clock_hz_q   <= cfg_data_i[CLK_W-1:0];
        CFG_TIME_LIMIT: time_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ipcr_front u_front (
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .timer_count_i    (timer_count_i),
    .pin_level_i      (pin_level_i),
    .carrier_period_i (carrier_period_i),
    .q_full_i         (q_full),
    .q_push_o         (q_push),
    .q_cmd_o          (push_cmd)
  );

  ipcr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .pop_i   (q_pop),
    .cmd_o   (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ipcr_back #(
    .MAX_INTERVALS (MAX_INTERVALS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clock_hz_i   (clock_hz_q),
    .time_limit_i (time_limit_q),
    .q_cmd_i      (head_cmd),
    .q_empty_i    (q_empty),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_res_o    (res)
  );

  assign result_kind_o    = res.result_kind;
  assign signal_level_o   = res.signal_level;
  assign duration_us_o    = res.duration_us;
  assign interval_count_o = res.interval_count;
  assign carrier_hz_o     = res.carrier_hz;
  assign last_o           = res.last;

endmodule
